// ===== src/bmon_pkg.sv =====
// Shared constants, item types and register codes of the battery average monitor.
package bmon_pkg;

    localparam int WINDOW_LENGTH = 10;

    localparam int ADC_W      = 12;
    localparam int MV_W       = 13;
    localparam int MV_MAX     = 8191;
    localparam int LEVEL_W    = 15;
    localparam int OFFSET_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // counts * SCALE_Q16 >> SCALE_SHIFT gives millivolts
    localparam int SCALE_Q16   = 103071;
    localparam int SCALE_W     = 17;
    localparam int SCALE_SHIFT = 16;
    localparam int RAW_W       = ADC_W + SCALE_W;

    // signed sum of a converted sample and the offset
    localparam int CAL_W = MV_W + 2;

    localparam int IDX_W = $clog2(WINDOW_LENGTH);
    localparam int SUM_W = $clog2(WINDOW_LENGTH * MV_MAX + 1);

    // divide by the window length as a multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT = 21;
    localparam int DIV_RECIP = (2 ** DIV_SHIFT + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int PROD_W    = SUM_W + DIV_SHIFT;

    localparam logic [LEVEL_W-1:0] WARNING_LEVEL_RESET = LEVEL_W'(3500);
    localparam logic [LEVEL_W-1:0] SHUTOFF_LEVEL_RESET = LEVEL_W'(3300);

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARNING_LEVEL = 2'd0,
        CFG_SHUTOFF_LEVEL = 2'd1,
        CFG_CAL_ENABLE    = 2'd2,
        CFG_CAL_OFFSET    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic             opcode;
        logic [ADC_W-1:0] adc_count;
        logic             power_good;
    } in_item_t;

    typedef struct packed {
        logic [MV_W-1:0] instant_mv;
        logic [MV_W-1:0] average_mv;
        logic            radio_on_request;
        logic            shutoff_alert;
        logic            warning_alert;
    } out_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [MV_W-1:0]  latest;
        logic             full;
    } win_stat_t;

endpackage

// ===== src/bmon_window.sv =====
// Sample ring with running sum, latest value and window-full flag.
module bmon_window (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [bmon_pkg::MV_W-1:0]   mv,
    output bmon_pkg::win_stat_t         stat
);

    logic [bmon_pkg::MV_W-1:0]  ring_reg [bmon_pkg::WINDOW_LENGTH];
    logic [bmon_pkg::IDX_W-1:0] idx_reg;
    logic [bmon_pkg::IDX_W-1:0] idx_next;
    logic [bmon_pkg::SUM_W-1:0] sum_reg;
    logic [bmon_pkg::SUM_W-1:0] sum_next;
    logic [bmon_pkg::SUM_W-1:0] sum_base;
    logic [bmon_pkg::MV_W-1:0]  latest_reg;
    logic                       full_reg;
    logic                       idx_last;

    assign idx_last = (idx_reg == bmon_pkg::IDX_W'(bmon_pkg::WINDOW_LENGTH - 1));
    assign idx_next = idx_last ? '0 : idx_reg + 1'b1;

    // drop the oldest entry once every slot holds a sample
    assign sum_base = full_reg ? sum_reg - bmon_pkg::SUM_W'(ring_reg[idx_reg]) : sum_reg;
    assign sum_next = sum_base + bmon_pkg::SUM_W'(mv);

    always_ff @(posedge aclk) begin
        if (push) begin
            ring_reg[idx_reg] <= mv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            sum_reg    <= '0;
            latest_reg <= '0;
            full_reg   <= 1'b0;
        end else if (push) begin
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            latest_reg <= mv;
            if (idx_last) begin
                full_reg <= 1'b1;
            end
        end
    end

    assign stat.sum    = sum_reg;
    assign stat.latest = latest_reg;
    assign stat.full   = full_reg;

endmodule

// ===== src/battery_average_low_voltage_monitor_core.sv =====
// Top level of the battery average and low-voltage monitor.
//
// Requests enter on s_valid/s_ready/s_data: a converter sample (opcode 0)
// or a monitor tick (opcode 1) carrying the power-good bit. Every request
// yields exactly one result on m_valid/m_ready/m_data, in request order.
// A sample updates the 10-entry window and reports the new instant and
// average voltage; a tick compares the average with the shut-off and
// warning levels and raises each one-shot alert once, until power good
// clears both latches (and asks for the radio to be switched on again if
// the shut-off alert had fired).
// The datapath is a five-stage pipeline: input register, scale multiply,
// calibration, window update, divide multiply, then the result register.
// One request per cycle is sustained while m_ready stays high.
// When m_ready is low, requests keep flowing into empty stages; s_ready
// drops only once every stage and the result register are full.
// Reset (aresetn low, synchronous) empties the pipeline, clears the window
// and the alert latches, and restores the level and calibration registers.
// Write cfg_we/cfg_index/cfg_wdata only while no request is in flight.
module battery_average_low_voltage_monitor_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bmon_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bmon_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [bmon_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmon_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic [bmon_pkg::LEVEL_W-1:0]  warn_level_reg;
    logic [bmon_pkg::LEVEL_W-1:0]  shut_level_reg;
    logic                          cal_en_reg;
    logic [bmon_pkg::OFFSET_W-1:0] cal_off_reg;

    // stage handshake
    logic cap1, cap2, cap3, cap4, cap5, cap_out;

    logic                 v1_reg;
    bmon_pkg::in_item_t   in1_reg;

    logic                        v2_reg;
    logic                        op2_reg;
    logic                        pg2_reg;
    logic [bmon_pkg::MV_W-1:0]   raw2_reg;
    logic [bmon_pkg::RAW_W-1:0]  raw_prod;

    logic                              v3_reg;
    logic                              op3_reg;
    logic                              pg3_reg;
    logic [bmon_pkg::MV_W-1:0]         mv3_reg;
    logic signed [bmon_pkg::CAL_W-1:0] cal_sum;
    logic [bmon_pkg::MV_W-1:0]         cal_mv;

    logic                 v4_reg;
    logic                 op4_reg;
    logic                 pg4_reg;
    logic                 win_push;
    bmon_pkg::win_stat_t  win_stat;

    logic                        v5_reg;
    logic                        op5_reg;
    logic                        pg5_reg;
    logic [bmon_pkg::MV_W-1:0]   latest5_reg;
    logic                        full5_reg;
    logic [bmon_pkg::PROD_W-1:0] quot5_reg;
    logic [bmon_pkg::MV_W-1:0]   avg5;

    logic                 m_valid_reg;
    bmon_pkg::out_item_t  m_data_reg;
    bmon_pkg::out_item_t  m_data_next;

    logic warn_latched_reg, warn_latched_next;
    logic shut_latched_reg, shut_latched_next;
    logic is_tick, shut_hit, warn_hit, ld_out;

    // a stage can load when it is empty or its content moves on
    assign cap_out = !m_valid_reg || m_ready;
    assign cap5    = !v5_reg || cap_out;
    assign cap4    = !v4_reg || cap5;
    assign cap3    = !v3_reg || cap4;
    assign cap2    = !v2_reg || cap3;
    assign cap1    = !v1_reg || cap2;
    assign s_ready = cap1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warn_level_reg <= bmon_pkg::WARNING_LEVEL_RESET;
            shut_level_reg <= bmon_pkg::SHUTOFF_LEVEL_RESET;
            cal_en_reg     <= 1'b0;
            cal_off_reg    <= '0;
        end else if (cfg_we) begin
            unique case (bmon_pkg::cfg_index_t'(cfg_index))
                bmon_pkg::CFG_WARNING_LEVEL: warn_level_reg <= cfg_wdata;
                bmon_pkg::CFG_SHUTOFF_LEVEL: shut_level_reg <= cfg_wdata;
                bmon_pkg::CFG_CAL_ENABLE:    cal_en_reg     <= cfg_wdata[0];
                bmon_pkg::CFG_CAL_OFFSET:    cal_off_reg    <= cfg_wdata[bmon_pkg::OFFSET_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cap1)    v1_reg      <= s_valid;
            if (cap2)    v2_reg      <= v1_reg;
            if (cap3)    v3_reg      <= v2_reg;
            if (cap4)    v4_reg      <= v3_reg;
            if (cap5)    v5_reg      <= v4_reg;
            if (cap_out) m_valid_reg <= v5_reg;
        end
    end

    // stage 1: request register
    always_ff @(posedge aclk) begin
        if (cap1 && s_valid) begin
            in1_reg <= s_data;
        end
    end

    // stage 2: scale counts to millivolts
    assign raw_prod = bmon_pkg::RAW_W'(in1_reg.adc_count) *
                      bmon_pkg::RAW_W'(bmon_pkg::SCALE_Q16);

    always_ff @(posedge aclk) begin
        if (cap2 && v1_reg) begin
            op2_reg  <= in1_reg.opcode;
            pg2_reg  <= in1_reg.power_good;
            raw2_reg <= raw_prod[bmon_pkg::SCALE_SHIFT +: bmon_pkg::MV_W];
        end
    end

    // stage 3: with calibration enabled, add the offset and clamp to the millivolt range
    assign cal_sum = $signed({2'b00, raw2_reg}) +
                     $signed({{(bmon_pkg::CAL_W - bmon_pkg::OFFSET_W){
                               cal_off_reg[bmon_pkg::OFFSET_W-1]}}, cal_off_reg});

    always_comb begin
        priority if (!cal_en_reg) begin
            cal_mv = raw2_reg;
        end else if (cal_sum[bmon_pkg::CAL_W-1]) begin
            cal_mv = '0;
        end else if (cal_sum[bmon_pkg::CAL_W-2:bmon_pkg::MV_W] != '0) begin
            cal_mv = bmon_pkg::MV_W'(bmon_pkg::MV_MAX);
        end else begin
            cal_mv = cal_sum[bmon_pkg::MV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cap3 && v2_reg) begin
            op3_reg <= op2_reg;
            pg3_reg <= pg2_reg;
            mv3_reg <= cal_mv;
        end
    end

    // stage 4: window state doubles as this stage's payload
    assign win_push = cap4 && v3_reg && (op3_reg == bmon_pkg::OP_SAMPLE);

    bmon_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (win_push),
        .mv      (mv3_reg),
        .stat    (win_stat)
    );

    always_ff @(posedge aclk) begin
        if (cap4 && v3_reg) begin
            op4_reg <= op3_reg;
            pg4_reg <= pg3_reg;
        end
    end

    // stage 5: sum times reciprocal of the window length
    always_ff @(posedge aclk) begin
        if (cap5 && v4_reg) begin
            op5_reg     <= op4_reg;
            pg5_reg     <= pg4_reg;
            latest5_reg <= win_stat.latest;
            full5_reg   <= win_stat.full;
            quot5_reg   <= bmon_pkg::PROD_W'(win_stat.sum) *
                           bmon_pkg::PROD_W'(bmon_pkg::DIV_RECIP);
        end
    end

    assign avg5 = full5_reg ? quot5_reg[bmon_pkg::DIV_SHIFT +: bmon_pkg::MV_W] : latest5_reg;

    // result stage: level checks and one-shot latches
    assign ld_out   = cap_out && v5_reg;
    assign is_tick  = (op5_reg == bmon_pkg::OP_TICK);
    assign shut_hit = is_tick && !pg5_reg && !shut_latched_reg &&
                      (bmon_pkg::LEVEL_W'(avg5) < shut_level_reg);
    assign warn_hit = is_tick && !pg5_reg && !warn_latched_reg &&
                      (bmon_pkg::LEVEL_W'(avg5) < warn_level_reg);

    always_comb begin
        shut_latched_next = shut_latched_reg;
        warn_latched_next = warn_latched_reg;
        if (is_tick) begin
            if (pg5_reg) begin
                shut_latched_next = 1'b0;
                warn_latched_next = 1'b0;
            end else begin
                shut_latched_next = shut_latched_reg || shut_hit;
                warn_latched_next = warn_latched_reg || warn_hit;
            end
        end
    end

    always_comb begin
        m_data_next.instant_mv       = latest5_reg;
        m_data_next.average_mv       = avg5;
        m_data_next.radio_on_request = is_tick && pg5_reg && shut_latched_reg;
        m_data_next.shutoff_alert    = shut_hit;
        m_data_next.warning_alert    = warn_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shut_latched_reg <= 1'b0;
            warn_latched_reg <= 1'b0;
        end else if (ld_out) begin
            shut_latched_reg <= shut_latched_next;
            warn_latched_reg <= warn_latched_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // input stalls only behind a full pipeline and a held result
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready))
        else $error("request stalled with room in the pipeline");

    // radio-on comes from a power-good tick, which never raises an alert
    a_radio_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.radio_on_request |->
            (!m_data_reg.shutoff_alert && !m_data_reg.warning_alert))
        else $error("radio-on request together with an alert");

    // window stays full once every slot has a sample
    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        win_stat.full |=> win_stat.full)
        else $error("window-full flag cleared");

    // a shut-off alert leaves the latch set
    a_shut_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_out && shut_hit |=> shut_latched_reg)
        else $error("shut-off alert without latch");

endmodule
